/* hw/rtl/bsm_pkg.sv */
// Shared widths, the pipeline state type and the Booth step function.
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

   // Operand width and how the Booth steps are spread over the pipeline
   localparam int OPERAND_WIDTH   = 16;
   localparam int PRODUCT_WIDTH   = 2 * OPERAND_WIDTH;
   localparam int STEPS_PER_STAGE = 4;
   localparam int NUM_STAGES      = (OPERAND_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int STAGE_IDX_W     = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
   localparam int STEP_IDX_W      = $clog2(NUM_STAGES * STEPS_PER_STAGE + 1);

   // Recoding of the pair (multiplier bit 0, bit below it)
   localparam logic [1:0] BOOTH_SUB = 2'b10;
   localparam logic [1:0] BOOTH_ADD = 2'b01;

   typedef logic [OPERAND_WIDTH-1:0] operand_type;
   typedef logic [STAGE_IDX_W-1:0]   stage_idx_type;

   // Datapath state carried from stage to stage
   typedef struct packed {
      operand_type acc;
      operand_type mq;
      logic        q1;
      operand_type md;
   } booth_state_type;

   // One radix-2 Booth step: add/subtract with wrap, then arithmetic shift right
   function automatic booth_state_type booth_step(input booth_state_type st);
      booth_state_type nx;
      operand_type     sum;
      nx  = st;
      sum = st.acc;
      case ({st.mq[0], st.q1})
         BOOTH_SUB: sum = st.acc - st.md;
         BOOTH_ADD: sum = st.acc + st.md;
         default:   sum = st.acc;
      endcase
      nx.q1  = st.mq[0];
      nx.mq  = {sum[0], st.mq[OPERAND_WIDTH-1:1]};
      nx.acc = {sum[OPERAND_WIDTH-1], sum[OPERAND_WIDTH-1:1]};
      return nx;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/booth_signed_multiplier.sv */
// Top level of the pipelined radix-2 Booth signed multiplier.
//
// Usage:
//  - Input: drive req_multiplicand and req_multiplier and raise start; the
//    pair is taken at each rising edge with start high and busy low. busy
//    stays low, so a new pair may be started in every cycle.
//  - Output: rsp_valid is high for exactly one cycle with the signed product
//    on rsp_product ({accumulator, multiplier register}); that cycle is the
//    transfer.
//  - Pipeline: each pair passes through the NUM_STAGES stage registers in
//    order, and rsp_valid is the valid bit of the last one. Throughput: one
//    pair per cycle. Each stage runs STEPS_PER_STAGE chained 16-bit
//    add/subtract and shift steps, which sets the stage depth.
//  - The most negative multiplicand wraps in the 16-bit accumulator as a
//    plain Booth datapath does.
//  - Reset (synchronous, active high) clears all stage valid bits; items in
//    flight are dropped. The receiver cannot stall, so nothing is held back.
`timescale 1ns / 1ps
`default_nettype none

module booth_signed_multiplier (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [bsm_pkg::OPERAND_WIDTH-1:0] req_multiplicand,
   input  wire logic signed [bsm_pkg::OPERAND_WIDTH-1:0] req_multiplier,
   output logic                                        rsp_valid,
   output logic signed [bsm_pkg::PRODUCT_WIDTH-1:0]    rsp_product
);
   import bsm_pkg::*;

   logic            stage_valid [NUM_STAGES+1];
   booth_state_type stage_state [NUM_STAGES+1];

   // Pipeline never refuses a pair
   assign busy = 1'b0;

   // Initial datapath state of a fresh pair
   always_comb begin
      stage_valid[0]     = start && !busy;
      stage_state[0].acc = '0;
      stage_state[0].mq  = req_multiplier;
      stage_state[0].q1  = 1'b0;
      stage_state[0].md  = req_multiplicand;
   end

   // Chain of Booth stages
   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      bsm_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .stage_index (STAGE_IDX_W'(s)),
         .in_valid    (stage_valid[s]),
         .in_state    (stage_state[s]),
         .out_valid   (stage_valid[s+1]),
         .out_state   (stage_state[s+1])
      );
   end

   // Result transfer
   assign rsp_valid   = stage_valid[NUM_STAGES];
   assign rsp_product = {stage_state[NUM_STAGES].acc, stage_state[NUM_STAGES].mq};

   // Every result traces back to a matching earlier start
   a_rsp_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, NUM_STAGES))
      else $error("result without a matching start");

   // A zero multiplicand gives a zero product
   a_zero_md: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_multiplicand, NUM_STAGES) == '0)) |-> (rsp_product == '0))
      else $error("nonzero product for zero multiplicand");

   // A zero multiplier gives a zero product
   a_zero_mq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_multiplier, NUM_STAGES) == '0)) |-> (rsp_product == '0))
      else $error("nonzero product for zero multiplier");

   // The pipeline takes a pair every cycle
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");

endmodule

`default_nettype wire

/* hw/rtl/bsm_stage.sv */
// One pipeline stage: a group of Booth steps followed by a register.
`timescale 1ns / 1ps
`default_nettype none

module bsm_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bsm_pkg::stage_idx_type   stage_index,
   input  wire logic                     in_valid,
   input  wire bsm_pkg::booth_state_type in_state,
   output logic                          out_valid,
   output bsm_pkg::booth_state_type      out_state
);
   import bsm_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   booth_state_type state_ff;
   booth_state_type state_in;

   // Steps of this stage; steps past the operand width are skipped
   always_comb begin
      logic [STEP_IDX_W-1:0] base;
      base     = STEP_IDX_W'(stage_index) * STEP_IDX_W'(STEPS_PER_STAGE);
      state_in = in_state;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
         if ((base + STEP_IDX_W'(k)) < STEP_IDX_W'(OPERAND_WIDTH)) begin
            state_in = booth_step(state_in);
         end
      end
      valid_in = in_valid;
   end

   // Valid bit is control and resets; the payload does not
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the pipelined radix-2 Booth signed multiplier.
`timescale 1ns / 1ps

module tb_top;

   import bsm_pkg::*;

   typedef logic [PRODUCT_WIDTH-1:0] product_type;

   // Cycles without any transfer before the run is declared hung
   localparam int unsigned STALL_LIMIT  = 200;
   localparam int unsigned RANDOM_PAIRS = 900;
   localparam int unsigned CALM_TAIL    = 150;
   localparam int unsigned DRAIN_PAIR   = 450;

   // Operand pair waiting for its product
   typedef struct {
      operand_type md;
      operand_type mr;
      product_type product;
   } pending_product_type;

   // Predicts products and checks them in order of arrival
   class product_scoreboard;
      pending_product_type pending_products[$];
      int unsigned         mismatch_count;
      int unsigned         checked_count;

      // Signed product as a W-step Booth datapath with a W-bit wrapping accumulator forms it
      function automatic product_type booth_product(operand_type md, operand_type mr);
         operand_type acc;
         operand_type mq;
         operand_type sum;
         logic        q1;
         acc = '0;
         mq  = mr;
         q1  = 1'b0;
         for (int i = 0; i < OPERAND_WIDTH; i++) begin
            case ({mq[0], q1})
               BOOTH_SUB: sum = acc - md;
               BOOTH_ADD: sum = acc + md;
               default:   sum = acc;
            endcase
            q1  = mq[0];
            mq  = {sum[0], mq[OPERAND_WIDTH-1:1]};
            acc = {sum[OPERAND_WIDTH-1], sum[OPERAND_WIDTH-1:1]};
         end
         return {acc, mq};
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= 20)
            $display("MISMATCH @%0t: %s", $realtime, msg);
      endtask

      function void note_pair(operand_type md, operand_type mr);
         pending_product_type entry;
         entry.md      = md;
         entry.mr      = mr;
         entry.product = booth_product(md, mr);
         pending_products.push_back(entry);
      endfunction

      task check_product(product_type got);
         pending_product_type entry;
         checked_count++;
         if (pending_products.size() == 0) begin
            report_mismatch($sformatf("product %h with no pair pending", got));
         end else begin
            entry = pending_products.pop_front();
            if (got !== entry.product)
               report_mismatch($sformatf("%0d * %0d: product %h, predicted %h",
                                         $signed(entry.md), $signed(entry.mr),
                                         got, entry.product));
         end
      endtask

      function int unsigned pending();
         return pending_products.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic signed [OPERAND_WIDTH-1:0]  req_multiplicand = '0;
   logic signed [OPERAND_WIDTH-1:0]  req_multiplier   = '0;
   logic                             rsp_valid;
   logic signed [PRODUCT_WIDTH-1:0]  rsp_product;

   product_scoreboard sb = new();
   int unsigned       pairs_sent;
   int unsigned       min_md_pairs;
   int unsigned       quiet_cycles;

   booth_signed_multiplier dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_multiplicand (req_multiplicand),
      .req_multiplier   (req_multiplier),
      .rsp_valid        (rsp_valid),
      .rsp_product      (rsp_product)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Transfer monitor, checker and hang watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (start && !busy) begin
            sb.note_pair(req_multiplicand, req_multiplier);
            pairs_sent++;
            if (req_multiplicand == {1'b1, {(OPERAND_WIDTH-1){1'b0}}})
               min_md_pairs++;
         end
         if (rsp_valid)
            sb.check_product(rsp_product);
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_top: errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Hold a pair on the request ports until the block takes it
   task automatic send_pair(operand_type md, operand_type mr);
      start            <= 1'b1;
      req_multiplicand <= md;
      req_multiplier   <= mr;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst(int unsigned cycles);
      start            <= 1'b0;
      req_multiplicand <= operand_type'($urandom);
      req_multiplier   <= operand_type'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Mostly uniform operands, with extremes, small values and single-bit patterns mixed in
   function automatic operand_type pick_operand();
      operand_type edges [5];
      operand_type val;
      edges = '{operand_type'(0), operand_type'(1), '1,
                {1'b0, {(OPERAND_WIDTH-1){1'b1}}}, {1'b1, {(OPERAND_WIDTH-1){1'b0}}}};
      case ($urandom_range(0, 9))
         6, 7:    val = edges[$urandom_range(0, 4)];
         8:       val = operand_type'($urandom_range(0, 15));
         9:       val = operand_type'(1) << $urandom_range(0, OPERAND_WIDTH - 1);
         default: val = operand_type'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0)
         val = ~val;
      return val;
   endfunction

   initial begin
      operand_type corners [5];
      int unsigned idle_pct;
      corners = '{operand_type'(0), operand_type'(1), '1,
                  {1'b0, {(OPERAND_WIDTH-1){1'b1}}}, {1'b1, {(OPERAND_WIDTH-1){1'b0}}}};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: every pairing of zero, one, minus one and both extremes
      foreach (corners[i])
         foreach (corners[j])
            send_pair(corners[i], corners[j]);

      // Random pairs; idle density changes per block of 100, calm at the end, one full drain midway
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         idle_pct = (n >= RANDOM_PAIRS - CALM_TAIL || (n / 100) % 3 == 0) ? 0 : 30;
         if (n == DRAIN_PAIR) begin
            start <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end else if ($urandom_range(0, 99) < idle_pct) begin
            idle_burst($urandom_range(1, 3));
         end
         send_pair(pick_operand(), pick_operand());
      end
      start <= 1'b0;

      // Drain, then give any stray product time to show up
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);

      $display("%0d operand pairs multiplied, %0d products checked, %0d mismatches",
               pairs_sent, sb.checked_count, sb.mismatch_count);
      $display("%0d pairs used the most negative multiplicand", min_md_pairs);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_stage.sv
hw/rtl/booth_signed_multiplier.sv
tb/sv/tb_top.sv
